// File: design/emgwin_pkg.sv
package emgwin_pkg;

  localparam int DEF_WINDOW_LEN = 256;
  localparam int DEF_STRIDE_LEN = 32;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W = 17;
  localparam int SQR_W = 31;
  localparam int THR_W = 15;
  localparam int FRAC_W = 8;
  localparam int OUT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam int SQRT_STEPS = 16;
  localparam int ROOT_CW = $clog2(SQRT_STEPS);

  localparam logic [THR_W-1:0] THR_RESET = 15'd800;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 8'd179;

  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_FRACTION = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_OLD_SQUARE,
    ST_UPDATE,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic square;
    logic old_square;
    logic update;
    logic div_init;
    logic root_init;
    logic root_step;
    logic load_out;
  } cmd_t;

  // Width of the running sum of magnitudes over a window of the given length.
  function automatic int abs_width(input int window);
    abs_width = 15 + $clog2(window + 1);
  endfunction

  // Width of the running sum of squared magnitudes.
  function automatic int sq_width(input int window);
    sq_width = 30 + $clog2(window + 1);
  endfunction

  // Magnitude of a two's complement sample; the most negative code gives 32768.
  function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_W-1:0] bits);
    if (bits[SAMPLE_W-1]) begin
      magnitude = 17'h10000 - {1'b0, bits};
    end else begin
      magnitude = {1'b0, bits};
    end
  endfunction

endpackage

// File: design/emg_window_mav_rms_hysteresis.sv
// EMG window features with a close/open decision. Each transfer on the input
// channel carries one signed Q12.4 sample; the block keeps the last WINDOW_LEN
// samples in a RAM with running sums of magnitudes and squares, and after the
// first full window, then once every STRIDE_LEN samples, it delivers the mean
// absolute value, the floored RMS, the raw threshold decision and the
// hysteresis hand state. WINDOW_LEN must be a power of two, since the window
// means are taken by shifting the sums. An item that produces no result passes
// through reading the oldest sample, squaring the new and the old magnitude in
// turn and updating the sums with the means before the next transfer is taken.
// An item that produces a result then also goes through one state that loads
// the square root, 16 root steps and one state that loads the output register,
// which waits while the previous result is held there under out_stall.
// The configuration port always accepts; write it only while the block is idle.
module emg_window_mav_rms_hysteresis #(
  parameter int WINDOW_LEN = emgwin_pkg::DEF_WINDOW_LEN,
  parameter int STRIDE_LEN = emgwin_pkg::DEF_STRIDE_LEN
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [emgwin_pkg::SAMPLE_W-1:0]    in_filtered_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [emgwin_pkg::OUT_W-1:0]       out_mean_abs,
  output logic [emgwin_pkg::OUT_W-1:0]       out_rms_level,
  output logic                               out_raw_closed,
  output logic                               out_hand_closed,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [emgwin_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [emgwin_pkg::CFG_DATA_W-1:0]  cfg_data
);

  emgwin_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  emgwin_ctrl #(
    .WINDOW_LEN(WINDOW_LEN),
    .STRIDE_LEN(STRIDE_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  emgwin_dp #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_filtered_sample (in_filtered_sample),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_mean_abs       (out_mean_abs),
    .out_rms_level      (out_rms_level),
    .out_raw_closed     (out_raw_closed),
    .out_hand_closed    (out_hand_closed)
  );

  // Once a sample transfers, the block is busy on it in the next cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input transfer not followed by stall");

  // A new result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending result");

  // Datapath steps other than div_init, which comes with update, are issued one at a time.
  a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.square, cmd.old_square, cmd.update,
              cmd.root_init, cmd.root_step, cmd.load_out}))
    else $error("more than one datapath step in a cycle");

  // A result appears only after the controller loaded it.
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("output valid without a load");

endmodule

// File: design/emgwin_ram.sv
module emgwin_ram #(
  parameter int WIDTH = emgwin_pkg::SAMPLE_W,
  parameter int DEPTH = emgwin_pkg::DEF_WINDOW_LEN
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/emgwin_ctrl.sv
module emgwin_ctrl #(
  parameter int WINDOW_LEN = emgwin_pkg::DEF_WINDOW_LEN,
  parameter int STRIDE_LEN = emgwin_pkg::DEF_STRIDE_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output emgwin_pkg::cmd_t  cmd
);

  localparam int CNT_MAX = (WINDOW_LEN > STRIDE_LEN) ? WINDOW_LEN : STRIDE_LEN;
  localparam int CW = $clog2(CNT_MAX + 1);

  emgwin_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] until_emit_r;
  logic [emgwin_pkg::ROOT_CW-1:0] root_cnt_r;
  logic out_valid_r;
  logic emit_due;
  logic slot_free;

  assign emit_due = !(until_emit_r > CW'(1));
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      emgwin_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = emgwin_pkg::ST_SQUARE;
        end
      end
      emgwin_pkg::ST_SQUARE:     state_nxt = emgwin_pkg::ST_OLD_SQUARE;
      emgwin_pkg::ST_OLD_SQUARE: state_nxt = emgwin_pkg::ST_UPDATE;
      emgwin_pkg::ST_UPDATE: begin
        state_nxt = emit_due ? emgwin_pkg::ST_ROOT_LOAD : emgwin_pkg::ST_IDLE;
      end
      emgwin_pkg::ST_ROOT_LOAD:  state_nxt = emgwin_pkg::ST_ROOT;
      emgwin_pkg::ST_ROOT: begin
        if (root_cnt_r == '0) begin
          state_nxt = emgwin_pkg::ST_EMIT;
        end
      end
      emgwin_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = emgwin_pkg::ST_IDLE;
        end
      end
      default: state_nxt = emgwin_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      emgwin_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      emgwin_pkg::ST_SQUARE:     cmd.square = 1'b1;
      emgwin_pkg::ST_OLD_SQUARE: cmd.old_square = 1'b1;
      emgwin_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        cmd.div_init = emit_due;
      end
      emgwin_pkg::ST_ROOT_LOAD:  cmd.root_init = 1'b1;
      emgwin_pkg::ST_ROOT:       cmd.root_step = 1'b1;
      emgwin_pkg::ST_EMIT:       cmd.load_out = slot_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= emgwin_pkg::ST_IDLE;
      until_emit_r <= CW'(WINDOW_LEN);
      root_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.update) begin
        until_emit_r <= emit_due ? CW'(STRIDE_LEN) : until_emit_r - CW'(1);
      end
      if (cmd.root_init) begin
        root_cnt_r <= emgwin_pkg::ROOT_CW'(emgwin_pkg::SQRT_STEPS - 1);
      end else if (cmd.root_step) begin
        root_cnt_r <= root_cnt_r - emgwin_pkg::ROOT_CW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: design/emgwin_dp.sv
module emgwin_dp #(
  parameter int WINDOW_LEN = emgwin_pkg::DEF_WINDOW_LEN
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  emgwin_pkg::cmd_t                    cmd,
  input  logic [emgwin_pkg::SAMPLE_W-1:0]     in_filtered_sample,
  input  logic                                cfg_we,
  input  logic [emgwin_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [emgwin_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [emgwin_pkg::OUT_W-1:0]        out_mean_abs,
  output logic [emgwin_pkg::OUT_W-1:0]        out_rms_level,
  output logic                                out_raw_closed,
  output logic                                out_hand_closed
);

  localparam int AW = $clog2(WINDOW_LEN);
  localparam int WLW = $clog2(WINDOW_LEN + 1);
  localparam int ABS_W = emgwin_pkg::abs_width(WINDOW_LEN);
  localparam int SQ_W = emgwin_pkg::sq_width(WINDOW_LEN);
  localparam int PROD_W = emgwin_pkg::THR_W + emgwin_pkg::FRAC_W;
  localparam int CMP_W = ABS_W + 8;
  localparam int ROOT_W = emgwin_pkg::SQR_W;
  localparam logic [WLW-1:0] WIN_CONST = WLW'(WINDOW_LEN);

  logic [emgwin_pkg::SAMPLE_W-1:0] sample_r;
  logic [emgwin_pkg::SAMPLE_W-1:0] old_sample;
  logic [emgwin_pkg::MAG_W-1:0] mag_r, oldmag_r;
  logic [emgwin_pkg::SQR_W-1:0] sq_r, osq_r;
  logic [ABS_W-1:0] abs_sum_r;
  logic [SQ_W-1:0] sq_sum_r, sq_sum_upd;
  logic [AW-1:0] pos_r;
  logic full_r;

  logic [emgwin_pkg::THR_W-1:0] thr_r;
  logic [emgwin_pkg::FRAC_W-1:0] frac_r;
  logic [PROD_W-1:0] tf_r;
  logic [CMP_W-1:0] rhs_r;
  logic [CMP_W-1:0] lhs;

  logic [emgwin_pkg::OUT_W-1:0] mean_q_r;
  logic [emgwin_pkg::SQR_W-1:0] msq_r;

  logic [ROOT_W-1:0] x_r, root_r, bit_r;
  logic [ROOT_W:0] cand;
  logic take;

  logic [emgwin_pkg::OUT_W-1:0] mean_r, rms_r;
  logic raw_r, gest_r;
  logic raw;

  emgwin_ram #(
    .WIDTH(emgwin_pkg::SAMPLE_W),
    .DEPTH(WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (cmd.square),
    .waddr (pos_r),
    .wdata (sample_r),
    .re    (cmd.capture),
    .raddr (pos_r),
    .rdata (old_sample)
  );

  assign sq_sum_upd = sq_sum_r - SQ_W'(osq_r) + SQ_W'(sq_r);

  assign cand = {1'b0, root_r} + {1'b0, bit_r};
  assign take = {1'b0, x_r} >= cand;

  assign raw = {1'b0, thr_r} <= mean_q_r;
  assign lhs = {abs_sum_r, 8'b0};

  // The open level is threshold * fraction * window, built over two registers.
  always_ff @(posedge clk) begin
    tf_r <= PROD_W'(thr_r) * PROD_W'(frac_r);
    rhs_r <= CMP_W'(tf_r) * CMP_W'(WIN_CONST);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_filtered_sample;
      mag_r <= emgwin_pkg::magnitude(in_filtered_sample);
    end
    if (cmd.square) begin
      sq_r <= emgwin_pkg::SQR_W'(mag_r) * emgwin_pkg::SQR_W'(mag_r);
      oldmag_r <= full_r ? emgwin_pkg::magnitude(old_sample) : '0;
    end
    if (cmd.old_square) begin
      osq_r <= emgwin_pkg::SQR_W'(oldmag_r) * emgwin_pkg::SQR_W'(oldmag_r);
    end
    // The window length is a power of two, so both means are the sums shifted right.
    if (cmd.div_init) begin
      mean_q_r <= abs_sum_r[AW +: emgwin_pkg::OUT_W];
      msq_r <= sq_sum_upd[AW +: emgwin_pkg::SQR_W];
    end
    if (cmd.root_init) begin
      x_r <= msq_r;
      root_r <= '0;
      bit_r <= ROOT_W'(1) << 30;
    end else if (cmd.root_step) begin
      x_r <= take ? ROOT_W'({1'b0, x_r} - cand) : x_r;
      root_r <= take ? (root_r >> 1) + bit_r : root_r >> 1;
      bit_r <= bit_r >> 2;
    end
    if (cmd.load_out) begin
      mean_r <= mean_q_r;
      rms_r <= root_r[emgwin_pkg::OUT_W-1:0];
      raw_r <= raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_sum_r <= '0;
      sq_sum_r <= '0;
      pos_r <= '0;
      full_r <= 1'b0;
      gest_r <= 1'b0;
      thr_r <= emgwin_pkg::THR_RESET;
      frac_r <= emgwin_pkg::FRAC_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          emgwin_pkg::REG_CLOSE_THRESHOLD: thr_r <= cfg_data;
          emgwin_pkg::REG_HYST_FRACTION:   frac_r <= cfg_data[emgwin_pkg::FRAC_W-1:0];
          default: ;
        endcase
      end
      if (cmd.old_square) begin
        abs_sum_r <= abs_sum_r - ABS_W'(oldmag_r) + ABS_W'(mag_r);
      end
      if (cmd.update) begin
        sq_sum_r <= sq_sum_upd;
        if (pos_r == AW'(WINDOW_LEN - 1)) begin
          pos_r <= '0;
          full_r <= 1'b1;
        end else begin
          pos_r <= pos_r + AW'(1);
        end
      end
      if (cmd.load_out) begin
        // Closing uses the floored mean; opening compares the exact window sum.
        if (!gest_r) begin
          gest_r <= raw;
        end else if (lhs < rhs_r) begin
          gest_r <= 1'b0;
        end
      end
    end
  end

  assign out_mean_abs = mean_r;
  assign out_rms_level = rms_r;
  assign out_raw_closed = raw_r;
  assign out_hand_closed = gest_r;

endmodule

// File: tb/sv/emg_window_mav_rms_hysteresis_test.sv
module emg_window_mav_rms_hysteresis_test;

  localparam int WIN = emgwin_pkg::DEF_WINDOW_LEN;
  localparam int STRIDE = emgwin_pkg::DEF_STRIDE_LEN;
  localparam int ITEM_SETTLE = 8;
  localparam int RESULT_SETTLE = 100;
  localparam int STUCK_LIMIT = 4000;
  localparam int FULL_RANGE = -1;

  // Indexes that map to no register; writes to them must be ignored.
  localparam logic [emgwin_pkg::CFG_IDX_W-1:0] UNMAPPED_REG_LO = 2'd2;
  localparam logic [emgwin_pkg::CFG_IDX_W-1:0] UNMAPPED_REG_HI = 2'd3;

  typedef struct packed {
    logic [emgwin_pkg::OUT_W-1:0] mean_abs;
    logic [emgwin_pkg::OUT_W-1:0] rms_level;
    logic raw_closed;
    logic hand_closed;
  } emg_features_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [emgwin_pkg::SAMPLE_W-1:0] in_filtered_sample;
  logic out_valid;
  logic out_stall;
  logic [emgwin_pkg::OUT_W-1:0] out_mean_abs;
  logic [emgwin_pkg::OUT_W-1:0] out_rms_level;
  logic out_raw_closed;
  logic out_hand_closed;
  logic cfg_valid;
  logic cfg_ready;
  logic [emgwin_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [emgwin_pkg::CFG_DATA_W-1:0] cfg_data;

  // Window model of the block.
  logic [15:0] window_samples [WIN];
  int unsigned next_slot = 0;
  longint unsigned mag_total = 0;
  longint unsigned square_total = 0;
  int unsigned until_emit = WIN;
  bit window_filled = 1'b0;
  bit hand_is_closed = 1'b0;
  logic [emgwin_pkg::THR_W-1:0] close_level = emgwin_pkg::THR_RESET;
  logic [emgwin_pkg::FRAC_W-1:0] open_fraction = emgwin_pkg::FRAC_RESET;

  emg_features_t expected_features [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int stuck_cycles = 0;

  logic [15:0] boundary_samples [16] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001, 16'h5555, 16'hAAAA,
    16'h00FF, 16'hFF00, 16'h0320, 16'hFCE0, 16'h4000, 16'hC000, 16'h7FFE, 16'h0002
  };

  emg_window_mav_rms_hysteresis #(
    .WINDOW_LEN(WIN),
    .STRIDE_LEN(STRIDE)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_filtered_sample(in_filtered_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_mean_abs(out_mean_abs),
    .out_rms_level(out_rms_level),
    .out_raw_closed(out_raw_closed),
    .out_hand_closed(out_hand_closed),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned sample_magnitude(input logic [15:0] s);
    int sv;
    sv = $signed(s);
    return (sv < 0) ? longint'(-sv) : longint'(sv);
  endfunction

  function automatic void update_window_model(input logic [15:0] s);
    longint unsigned mag;
    longint unsigned old_mag;
    longint unsigned mean;
    longint unsigned mean_square;
    longint unsigned root;
    longint unsigned trial;
    bit raw;
    emg_features_t feat;
    mag = sample_magnitude(s);
    // While the window is still filling, nothing leaves it.
    if (window_filled) begin
      old_mag = sample_magnitude(window_samples[next_slot]);
      mag_total -= old_mag;
      square_total -= old_mag * old_mag;
    end
    window_samples[next_slot] = s;
    mag_total += mag;
    square_total += mag * mag;
    next_slot++;
    if (next_slot == WIN) begin
      next_slot = 0;
      window_filled = 1'b1;
    end
    if (until_emit > 1) begin
      until_emit--;
      return;
    end
    until_emit = STRIDE;
    mean = mag_total / WIN;
    mean_square = square_total / WIN;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= mean_square) root = trial;
    end
    raw = (mean >= 64'(close_level));
    if (!hand_is_closed) begin
      hand_is_closed = raw;
    end else if (mag_total * 256 < 64'(close_level) * 64'(open_fraction) * 64'(WIN)) begin
      // The open level is compared against the exact mean, not the floored one.
      hand_is_closed = 1'b0;
    end
    feat.mean_abs = mean[15:0];
    feat.rms_level = root[15:0];
    feat.raw_closed = raw;
    feat.hand_closed = hand_is_closed;
    expected_features.push_back(feat);
  endfunction

  task automatic send_sample(input logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_filtered_sample <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    update_window_model(value);
  endtask

  // Level sets the spread of magnitudes around the mean; FULL_RANGE draws raw codes.
  task automatic send_burst(input int count, input int level);
    int mag;
    repeat (count) begin
      if (level == FULL_RANGE) begin
        send_sample(16'($urandom_range(65535)));
      end else begin
        mag = $urandom_range(2 * level, 0);
        if (mag > 32767) mag = 32767;
        send_sample($urandom_range(1) ? 16'(-mag) : 16'(mag));
      end
    end
  endtask

  task automatic write_register(input logic [emgwin_pkg::CFG_IDX_W-1:0] idx,
                                input logic [emgwin_pkg::CFG_DATA_W-1:0] data,
                                input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == emgwin_pkg::REG_CLOSE_THRESHOLD) begin
      close_level = data[emgwin_pkg::THR_W-1:0];
    end else if (idx == emgwin_pkg::REG_HYST_FRACTION) begin
      open_fraction = data[emgwin_pkg::FRAC_W-1:0];
    end
    if (last) cfg_valid <= 1'b0;
  endtask

  // Waits until every expected result has arrived and the last item has left the pipeline.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_features.size() != 0);
    repeat (ITEM_SETTLE) @(posedge clk);
  endtask

  task automatic test_reset_config_edges();
    foreach (boundary_samples[i]) send_sample(boundary_samples[i]);
    send_burst(140, 1400);
    send_burst(140, 300);
  endtask

  task automatic test_fraction_zero_masking();
    wait_idle();
    write_register(UNMAPPED_REG_LO, 15'h7FFF, 1'b0);
    write_register(UNMAPPED_REG_HI, 15'h7FFF, 1'b0);
    // Only the low eight bits reach the fraction, so this leaves it at zero.
    write_register(emgwin_pkg::REG_HYST_FRACTION, 15'h7F00, 1'b0);
    write_register(emgwin_pkg::REG_CLOSE_THRESHOLD, 15'd600, 1'b1);
    send_burst(64, 1500);
    send_burst(96, 40);
  endtask

  task automatic test_threshold_zero();
    wait_idle();
    write_register(emgwin_pkg::REG_CLOSE_THRESHOLD, 15'd0, 1'b0);
    write_register(emgwin_pkg::REG_HYST_FRACTION, 15'd128, 1'b1);
    send_burst(96, 0);
  endtask

  task automatic test_full_scale();
    wait_idle();
    write_register(emgwin_pkg::REG_CLOSE_THRESHOLD, 15'h7FFF, 1'b0);
    write_register(emgwin_pkg::REG_HYST_FRACTION, 15'h00FF, 1'b1);
    send_burst(32, 0);
    // A window made only of the most negative code gives a mean and RMS of 32768.
    repeat (WIN + STRIDE) send_sample(16'h8000);
    send_burst(64, 30);
  endtask

  task automatic test_output_backpressure();
    hold_request = 600;
    send_burst(160, 900);
    wait_idle();
    send_burst(48, 300);
  endtask

  task automatic test_random_traffic(input int count);
    int sent;
    int len;
    int level;
    int lo;
    int hi;
    logic [emgwin_pkg::THR_W-1:0] thr;
    logic [emgwin_pkg::FRAC_W-1:0] frac;
    wait_idle();
    case ($urandom_range(5))
      0: thr = '0;
      1: thr = 15'h7FFF;
      2, 3: thr = 15'($urandom_range(1500, 100));
      4: thr = 15'($urandom_range(32767));
      default: thr = emgwin_pkg::THR_RESET;
    endcase
    case ($urandom_range(3))
      0: frac = '0;
      1: frac = 8'hFF;
      default: frac = 8'($urandom_range(255));
    endcase
    write_register($urandom_range(1) ? UNMAPPED_REG_LO : UNMAPPED_REG_HI,
                   15'($urandom_range(32767)), 1'b0);
    write_register(emgwin_pkg::REG_CLOSE_THRESHOLD, thr, 1'b0);
    write_register(emgwin_pkg::REG_HYST_FRACTION, {7'($urandom_range(127)), frac}, 1'b1);
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(120, 8);
      if (len > count - sent) len = count - sent;
      case ($urandom_range(7))
        0: level = FULL_RANGE;
        1: level = $urandom_range(20);
        2: level = $urandom_range(16383);
        default: begin
          // Keep the window mean wandering through the hysteresis band.
          lo = int'(thr) * int'(frac) / 512;
          hi = int'(thr) * 3 / 2 + 32;
          level = $urandom_range(hi, lo);
        end
      endcase
      send_burst(len, level);
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    emg_features_t want;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_features.size() == 0) begin
        $error("unexpected result transfer: mean_abs %0d rms_level %0d",
               out_mean_abs, out_rms_level);
        errors++;
      end else begin
        want = expected_features.pop_front();
        if (out_mean_abs !== want.mean_abs) begin
          $error("mean_abs: expected %0d, actual %0d", want.mean_abs, out_mean_abs);
          errors++;
        end
        if (out_rms_level !== want.rms_level) begin
          $error("rms_level: expected %0d, actual %0d", want.rms_level, out_rms_level);
          errors++;
        end
        if (out_raw_closed !== want.raw_closed) begin
          $error("raw_closed: expected %0d, actual %0d", want.raw_closed, out_raw_closed);
          errors++;
        end
        if (out_hand_closed !== want.hand_closed) begin
          $error("hand_closed: expected %0d, actual %0d", want.hand_closed, out_hand_closed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)
        || (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_filtered_sample <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    send_idle_pct = 35;
    recv_idle_pct = 64;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_config_edges();
    test_fraction_zero_masking();
    test_threshold_zero();
    test_full_scale();
    test_random_traffic(200);

    send_idle_pct = 64;
    recv_idle_pct = 35;
    test_random_traffic(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_traffic(200);

    wait_idle();
    repeat (RESULT_SETTLE) @(posedge clk);
    if (errors == 0 && expected_features.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
